// ===== design/tdf_pkg.sv =====
package tdf_pkg;

    typedef enum logic [1:0] {
        MODE_BOX    = 2'd0,
        MODE_WEIGHT = 2'd1,
        MODE_MEDIAN = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ONE  = 2'd1,
        FILL_TWO  = 2'd2
    } t_fill;

    typedef enum logic [1:0] {
        JOB_ONE  = 2'd0,
        JOB_PAIR = 2'd1,
        JOB_PASS = 2'd2
    } t_job_kind;

    localparam int KIND_W    = 2;
    localparam int BOX_SHIFT = 16;
    localparam int MUL_W     = 17;
    localparam logic signed [MUL_W-1:0] BOX_MUL = 17'sd21846;
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

endpackage

// ===== design/three_tap_denoise_filter.sv =====
// channel   direction  handshake                 fields
// input     in         push / full               i_sample, i_last_sample
// result    out        empty / pop               o_filtered, o_last_result
// config    in         i_cfg_we                  i_cfg_wdata (filter_mode)
//
// one word accepted per cycle while full is low; a last word after others yields two
// results from the kernel unit, a lone last word one, so a run of n words gives n results
// a result reaches the ports by way of the job queue, then the result queue, after the
// word that completes it
// synchronous active-low reset empties both queues and clears the window, mode to box
// full rises only when the job queue holds four words; empty tracks the result queue
module three_tap_denoise_filter #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_sample,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered,
    output logic                           o_last_result,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_wdata
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int JOB_W = 3 * W + tdf_pkg::KIND_W;

    logic [1:0]          r_filter_mode;
    logic                job_wr, job_full, job_rd, job_empty;
    logic [JOB_W-1:0]    job_wdata, job_rdata;
    logic                res_wr;
    logic                res_full;
    logic [W:0]          res_wdata, res_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= tdf_pkg::MODE_BOX;
        end else if (i_cfg_we) begin
            r_filter_mode <= i_cfg_wdata;
        end
    end

    assign full = job_full;

    tdf_front #(.SAMPLE_WIDTH(W)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (push && !job_full),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_job_wr      (job_wr),
        .o_job         (job_wdata)
    );

    tdf_fifo #(.WIDTH(JOB_W), .DEPTH(tdf_pkg::JOB_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_wdata),
        .o_full  (job_full),
        .i_rd    (job_rd),
        .o_rdata (job_rdata),
        .o_empty (job_empty)
    );

    tdf_back #(.SAMPLE_WIDTH(W)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_filter_mode (r_filter_mode),
        .i_job         (job_rdata),
        .i_job_empty   (job_empty),
        .o_job_rd      (job_rd),
        .i_res_full    (res_full),
        .o_res_wr      (res_wr),
        .o_res_data    (res_wdata)
    );

    tdf_fifo #(.WIDTH(W + 1), .DEPTH(tdf_pkg::RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_wdata),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_filtered    = res_rdata[W-1:0];
    assign o_last_result = res_rdata[W];

endmodule

// ===== design/tdf_fifo.sv =====
module tdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fifo count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("fifo count did not grow on write");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CNT_W'(DEPTH)) |-> (PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count)))
        else $error("fifo pointers disagree with count");

endmodule

// ===== design/tdf_front.sv =====
module tdf_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_job_wr,
    output logic [3*SAMPLE_WIDTH+tdf_pkg::KIND_W-1:0] o_job
);

    localparam int W = SAMPLE_WIDTH;

    tdf_pkg::t_fill     r_fill, n_fill;
    logic signed [W-1:0] r_older, n_older;
    logic signed [W-1:0] r_newer, n_newer;
    tdf_pkg::t_job_kind job_kind;
    logic signed [W-1:0] job_a, job_b, job_c;

    always_comb begin
        n_fill  = r_fill;
        n_older = r_older;
        n_newer = r_newer;
        if (i_accept) begin
            if (i_last_sample) begin
                n_fill = tdf_pkg::FILL_NONE;
            end else begin
                unique case (r_fill)
                    tdf_pkg::FILL_NONE: begin
                        n_fill  = tdf_pkg::FILL_ONE;
                        n_newer = i_sample;
                    end
                    default: begin
                        n_fill  = tdf_pkg::FILL_TWO;
                        n_older = r_newer;
                        n_newer = i_sample;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_job_wr = 1'b0;
        job_kind = i_last_sample ? tdf_pkg::JOB_PAIR : tdf_pkg::JOB_ONE;
        job_a    = i_sample;
        job_b    = r_newer;
        job_c    = i_sample;
        unique case (r_fill)
            tdf_pkg::FILL_NONE: begin
                o_job_wr = i_accept && i_last_sample;
                job_kind = tdf_pkg::JOB_PASS;
            end
            tdf_pkg::FILL_ONE: begin
                o_job_wr = i_accept;
            end
            default: begin
                o_job_wr = i_accept;
                job_a    = r_older;
            end
        endcase
    end

    assign o_job = {job_kind, job_a, job_b, job_c};

    always_ff @(posedge i_clk) begin
        r_older <= n_older;
        r_newer <= n_newer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= tdf_pkg::FILL_NONE;
        end else begin
            r_fill <= n_fill;
        end
    end

    a_pass_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_wr && job_kind == tdf_pkg::JOB_PASS) |-> r_fill == tdf_pkg::FILL_NONE)
        else $error("pass-through word with a filled window");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_sample) |=> r_fill == tdf_pkg::FILL_NONE)
        else $error("window not cleared after last word");

    a_first_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_sample && r_fill == tdf_pkg::FILL_NONE) |-> !o_job_wr)
        else $error("job issued for first word of a run");

endmodule

// ===== design/tdf_back.sv =====
module tdf_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_filter_mode,
    input  logic [3*SAMPLE_WIDTH+tdf_pkg::KIND_W-1:0] i_job,
    input  logic                          i_job_empty,
    output logic                          o_job_rd,
    input  logic                          i_res_full,
    output logic                          o_res_wr,
    output logic [SAMPLE_WIDTH:0]         o_res_data
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int SUM_W = W + 2;
    localparam int PRD_W = SUM_W + tdf_pkg::MUL_W;
    localparam int SH_W  = PRD_W - tdf_pkg::BOX_SHIFT;

    tdf_pkg::t_job_kind kind;
    logic signed [W-1:0]     ja, jb, jc, x, y, z;
    logic signed [SUM_W-1:0] sum3;
    logic signed [PRD_W-1:0] prod;
    logic signed [SH_W-1:0]  box_sh;
    logic signed [W-1:0]     box_val, wgt_val, med_val, lo, hi, value;
    logic signed [W+2:0]     wsum;
    logic                    sat_hi, sat_lo, emit, last_flag;
    logic                    r_second, n_second;

    assign kind = tdf_pkg::t_job_kind'(i_job[3*W+tdf_pkg::KIND_W-1:3*W]);
    assign ja   = i_job[3*W-1:2*W];
    assign jb   = i_job[2*W-1:W];
    assign jc   = i_job[W-1:0];

    assign x = r_second ? jb : ja;
    assign y = r_second ? jc : jb;
    assign z = r_second ? jb : jc;

    assign sum3   = SUM_W'(x) + SUM_W'(y) + SUM_W'(z);
    assign prod   = sum3 * tdf_pkg::BOX_MUL;
    assign box_sh = prod[PRD_W-1:tdf_pkg::BOX_SHIFT];
    assign sat_hi = !box_sh[SH_W-1] && (|box_sh[SH_W-2:W-1]);
    assign sat_lo = box_sh[SH_W-1] && !(&box_sh[SH_W-2:W-1]);

    always_comb begin
        if (sat_hi) begin
            box_val = {1'b0, {(W-1){1'b1}}};
        end else if (sat_lo) begin
            box_val = {1'b1, {(W-1){1'b0}}};
        end else begin
            box_val = box_sh[W-1:0];
        end
    end

    assign wsum    = (W+3)'(x) + ((W+3)'(y) <<< 1) + (W+3)'(z);
    assign wgt_val = wsum[W+1:2];

    always_comb begin
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        if (z <= lo) begin
            med_val = lo;
        end else if (z >= hi) begin
            med_val = hi;
        end else begin
            med_val = z;
        end
    end

    always_comb begin
        unique case (tdf_pkg::t_mode'(i_filter_mode))
            tdf_pkg::MODE_BOX:    value = box_val;
            tdf_pkg::MODE_WEIGHT: value = wgt_val;
            default:              value = med_val;
        endcase
        if (kind == tdf_pkg::JOB_PASS) begin
            value = jc;
        end
    end

    assign emit      = !i_job_empty && !i_res_full;
    assign last_flag = (kind == tdf_pkg::JOB_PASS) || (kind == tdf_pkg::JOB_PAIR && r_second);
    assign o_job_rd  = emit && (kind != tdf_pkg::JOB_PAIR || r_second);

    assign o_res_wr   = emit;
    assign o_res_data = {last_flag, value};

    always_comb begin
        n_second = r_second;
        if (emit) begin
            n_second = (kind == tdf_pkg::JOB_PAIR) && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    a_second_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_job_empty && kind == tdf_pkg::JOB_PAIR))
        else $error("second result without a pending pair");

    a_pair_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_second) |-> (o_job_rd && last_flag))
        else $error("pair did not retire on its flagged result");

    a_first_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && kind == tdf_pkg::JOB_PAIR && !r_second) |-> !o_job_rd)
        else $error("pair retired early");

endmodule

// ===== dv/tb_three_tap_denoise_filter.sv =====
`timescale 1ns / 100ps

module tb_three_tap_denoise_filter;

    localparam int SW = 16;
    localparam longint BOX_GAIN = 21846;
    localparam int BOX_BITS = 16;
    localparam logic [1:0] MODE_ALIAS = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int SHOW_LIMIT = 10;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last_flag;
    } t_in_word;

    typedef struct {
        logic signed [SW-1:0] filtered;
        logic                 last_flag;
    } t_filt_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic signed [SW-1:0] i_sample = '0;
    logic                 i_last_sample = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [SW-1:0] o_filtered;
    logic                 o_last_result;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_wdata = '0;

    three_tap_denoise_filter #(
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .empty        (empty),
        .pop          (pop),
        .o_filtered   (o_filtered),
        .o_last_result(o_last_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_in_word             pending_words[$];
    t_filt_word           filtered_due[$];

    tdf_pkg::t_mode       mode_q = tdf_pkg::MODE_BOX;
    tdf_pkg::t_fill       fill_q = tdf_pkg::FILL_NONE;
    logic signed [SW-1:0] older_q = '0;
    logic signed [SW-1:0] newer_q = '0;

    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   gap_left = 0;
    int                   burst_left = 0;
    bit                   steady = 1'b0;
    int                   pop_tick = 0;
    int                   pop_style = 0;
    t_in_word             next_word;
    t_filt_word           due_word;

    function automatic logic signed [SW-1:0] filter_tap(input logic signed [SW-1:0] a,
                                                        input logic signed [SW-1:0] b,
                                                        input logic signed [SW-1:0] c);
        longint acc;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        case (mode_q)
            tdf_pkg::MODE_BOX: begin
                acc = longint'(a) + longint'(b) + longint'(c);
                acc = (acc * BOX_GAIN) >>> BOX_BITS;
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                return acc[SW-1:0];
            end
            tdf_pkg::MODE_WEIGHT: begin
                acc = (longint'(a) + 2 * longint'(b) + longint'(c)) >>> 2;
                return acc[SW-1:0];
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                if (c <= lo) return lo;
                if (c >= hi) return hi;
                return c;
            end
        endcase
    endfunction

    // window update and expected results for one accepted word
    task automatic take_word(input logic signed [SW-1:0] s, input logic last_flag);
        if (fill_q == tdf_pkg::FILL_NONE) begin
            if (last_flag) begin
                filtered_due.push_back('{s, 1'b1});
            end else begin
                newer_q = s;
                fill_q  = tdf_pkg::FILL_ONE;
            end
        end else begin
            if (fill_q == tdf_pkg::FILL_ONE) begin
                filtered_due.push_back('{filter_tap(s, newer_q, s), 1'b0});
            end else begin
                filtered_due.push_back('{filter_tap(older_q, newer_q, s), 1'b0});
            end
            if (last_flag) begin
                filtered_due.push_back('{filter_tap(newer_q, s, newer_q), 1'b1});
                older_q = '0;
                newer_q = '0;
                fill_q  = tdf_pkg::FILL_NONE;
            end else begin
                older_q = newer_q;
                newer_q = s;
                fill_q  = tdf_pkg::FILL_TWO;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                take_word(i_sample, i_last_sample);
            end
            if (!push || !full) begin
                if (gap_left != 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    i_sample      <= next_word.sample;
                    i_last_sample <= next_word.last_flag;
                    push          <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = steady ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (filtered_due.size() == 0) begin
                    if (fail_count < SHOW_LIMIT) begin
                        $display("unexpected word: filtered=%0d last=%0b", o_filtered,
                                 o_last_result);
                    end
                    fail_count++;
                end else begin
                    due_word = filtered_due.pop_front();
                    if (o_filtered !== due_word.filtered ||
                        o_last_result !== due_word.last_flag) begin
                        if (fail_count < SHOW_LIMIT) begin
                            $display("mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
                                     due_word.filtered, o_filtered, due_word.last_flag,
                                     o_last_result);
                        end
                        fail_count++;
                    end
                end
            end
            pop_tick++;
            if (pop_tick % 256 == 0) begin
                pop_style = $urandom_range(0, 3);
            end
            case (pop_style)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (pop_tick % 16 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_three_tap_denoise_filter NOT OK");
            $finish;
        end
    end

    function automatic logic signed [SW-1:0] pick_sample();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3: begin
                v = $urandom_range(0, 63);
                return 16'(v) - 16'sd32;
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put(input logic signed [SW-1:0] s, input logic last_flag);
        pending_words.push_back('{s, last_flag});
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_words.size() != 0 || push || filtered_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] code);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        mode_q = (code == MODE_ALIAS) ? tdf_pkg::MODE_MEDIAN : tdf_pkg::t_mode'(code);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int run_len;
        int phase_words;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: box mode with saturation and short runs
        set_mode(tdf_pkg::MODE_BOX);
        steady = 1'b1;
        put(16'sh8000, 1'b1);
        put(16'sh7fff, 1'b1);
        put(16'sh8000, 1'b0);
        put(16'sh8000, 1'b1);
        put(16'sh7fff, 1'b0);
        put(16'sh7fff, 1'b0);
        put(16'sh7fff, 1'b1);
        put(16'sh0000, 1'b0);
        put(-16'sd1, 1'b0);
        put(16'sd1, 1'b0);
        put(16'sh8000, 1'b0);
        put(16'sh7fff, 1'b1);

        set_mode(tdf_pkg::MODE_WEIGHT);
        put(16'sh8000, 1'b0);
        put(16'sh7fff, 1'b0);
        put(-16'sd1, 1'b0);
        put(16'sh8000, 1'b1);

        set_mode(tdf_pkg::MODE_MEDIAN);
        put(16'sh7fff, 1'b0);
        put(16'sh8000, 1'b0);
        put(16'sd5, 1'b0);
        put(-16'sd5, 1'b1);

        // unused selector acts as median
        set_mode(MODE_ALIAS);
        put(16'sd100, 1'b0);
        put(16'sh8000, 1'b0);
        put(16'sh7fff, 1'b1);

        for (int p = 0; p < 8; p++) begin
            set_mode(2'($urandom_range(0, 3)));
            steady = ($urandom_range(0, 3) == 0);
            phase_words = 0;
            while (phase_words < 160) begin
                run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 20);
                for (int k = 0; k < run_len; k++) begin
                    put(pick_sample(), k == run_len - 1);
                end
                phase_words += run_len;
            end
            // broken run left open across the mode change
            if ($urandom_range(0, 3) == 0) begin
                run_len = $urandom_range(1, 2);
                for (int k = 0; k < run_len; k++) begin
                    put(pick_sample(), 1'b0);
                end
            end
        end

        drain();
        if (fail_count == 0 && filtered_due.size() == 0) begin
            $display("tb_three_tap_denoise_filter OK");
        end else begin
            $display("tb_three_tap_denoise_filter NOT OK");
        end
        $finish;
    end

endmodule
